[rtl/rcdf_pkg.sv]
// ----------------------------------------------------------------------------
// rcdf_pkg
// Shared types, constants and register codes of the command frame encoder.
// ----------------------------------------------------------------------------
package rcdf_pkg;

  // frame geometry
  localparam int unsigned FRAME_LEN  = 40;
  localparam int unsigned IDX_W      = 6;
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CNT0   = 6'd12;
  localparam logic [IDX_W-1:0] IDX_SYNC   = 6'd16;
  localparam logic [IDX_W-1:0] IDX_ROLL   = 6'd17;
  localparam logic [IDX_W-1:0] IDX_PITCH  = 6'd18;
  localparam logic [IDX_W-1:0] IDX_THR    = 6'd19;
  localparam logic [IDX_W-1:0] IDX_YAW    = 6'd20;
  localparam logic [IDX_W-1:0] IDX_FLAGS  = 6'd21;
  localparam logic [IDX_W-1:0] IDX_CHECK  = 6'd22;
  localparam logic [IDX_W-1:0] IDX_END    = 6'd23;

  localparam logic [7:0] SYNC_BYTE = 8'h66;
  localparam logic [7:0] END_BYTE  = 8'h99;
  localparam logic [7:0] FLAG_BASE = 8'h40;

  // fixed header bytes 0..11
  localparam logic [7:0] HEADER [12] = '{
    8'hef, 8'h02, 8'h28, 8'h00, 8'h02, 8'h02,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // stick scaling: offset, then floor(m * 63 / 250) by reciprocal multiply
  localparam logic [11:0] STICK_MID    = 12'd1000;
  localparam logic [18:0] SCALE_RECIP  = 19'd268436;
  localparam int unsigned SCALE_SHIFT  = 26;
  localparam logic [7:0]  STICK_BIAS   = 8'd2;

  // button counter limits
  localparam logic [6:0] BTN_RELEASE  = 7'd50;
  localparam logic [6:0] BTN_CAP      = 7'd100;

  // queue depth default
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUTTON_THR = 2'd0,
    CFG_SWITCH_THR = 2'd1,
    CFG_PULSE_FRM  = 2'd2,
    CFG_BEEP_INT   = 2'd3
  } cfg_reg_e;

  localparam logic [11:0] RST_BUTTON_THR = 12'd1900;
  localparam logic [11:0] RST_SWITCH_THR = 12'd1750;
  localparam logic [6:0]  RST_PULSE_FRM  = 7'd22;
  localparam logic [15:0] RST_BEEP_INT   = 16'd1000;

  typedef struct packed {
    logic [11:0] button_thr;
    logic [11:0] switch_thr;
    logic [6:0]  pulse_frames;
    logic [15:0] beep_interval;
  } rcdf_cfg_t;

  // one frame worth of variable fields, front to back
  typedef struct packed {
    logic [31:0] frame_count;
    logic [7:0]  roll;
    logic [7:0]  pitch;
    logic [7:0]  throttle;
    logic [7:0]  yaw;
    logic [7:0]  flags;
    logic [7:0]  check;
    logic [6:0]  event_mask;
  } rcdf_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rcdf_qstat_t;

  typedef struct packed {
    logic [6:0] cnt;
    logic       fired;
  } rcdf_btn_t;

endpackage

[rtl/rcdf_req_if.sv]
// ----------------------------------------------------------------------------
// rcdf_req_if
// Frame request channel: ten RC channel values and the time in ms.
// ----------------------------------------------------------------------------
interface rcdf_req_if;
  logic        valid;
  logic        ready;
  logic [11:0] roll_value;
  logic [11:0] pitch_value;
  logic [11:0] throttle_value;
  logic [11:0] yaw_value;
  logic [11:0] takeoff_value;
  logic [11:0] landing_value;
  logic [11:0] stop_value;
  logic [11:0] headless_value;
  logic [11:0] flip_value;
  logic [11:0] gyro_value;
  logic [31:0] now_ms;

  modport source (
    output valid, roll_value, pitch_value, throttle_value, yaw_value,
           takeoff_value, landing_value, stop_value, headless_value,
           flip_value, gyro_value, now_ms,
    input  ready
  );

  modport sink (
    input  valid, roll_value, pitch_value, throttle_value, yaw_value,
           takeoff_value, landing_value, stop_value, headless_value,
           flip_value, gyro_value, now_ms,
    output ready
  );
endinterface

[rtl/rcdf_rsp_if.sv]
// ----------------------------------------------------------------------------
// rcdf_rsp_if
// Frame byte channel: one frame byte, last marker and event mask.
// ----------------------------------------------------------------------------
interface rcdf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic [6:0] event_mask;

  modport source (
    output valid, frame_byte, last_byte, event_mask,
    input  ready
  );

  modport sink (
    input  valid, frame_byte, last_byte, event_mask,
    output ready
  );
endinterface

[rtl/rc_channels_to_drone_command_frame_core.sv]
// ----------------------------------------------------------------------------
// rc_channels_to_drone_command_frame_core
// Encodes one RC frame request into a 40-byte command frame with events.
// ----------------------------------------------------------------------------
// an accepted request passes stages p1 and p2 and the descriptor queue (DEPTH)
// ahead of the output register; bytes leave one per cycle while out_ch.ready
// holds; requests are taken every cycle unless p2 is held by a full queue
// reset: synchronous active-low rst_n clears counters, switch and beep state,
// the queue and the output, and loads the register defaults
module rc_channels_to_drone_command_frame_core import rcdf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rcdf_req_if.sink              in_ch,
  rcdf_rsp_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rcdf_cfg_t   cfg_r;
  rcdf_qstat_t qstat;
  rcdf_desc_t  push_desc;
  rcdf_desc_t  head_desc;
  logic        push;
  logic        pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_thr    <= RST_BUTTON_THR;
      cfg_r.switch_thr    <= RST_SWITCH_THR;
      cfg_r.pulse_frames  <= RST_PULSE_FRM;
      cfg_r.beep_interval <= RST_BEEP_INT;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_BUTTON_THR: cfg_r.button_thr    <= cfg_wdata[11:0];
        CFG_SWITCH_THR: cfg_r.switch_thr    <= cfg_wdata[11:0];
        CFG_PULSE_FRM:  cfg_r.pulse_frames  <= cfg_wdata[6:0];
        CFG_BEEP_INT:   cfg_r.beep_interval <= cfg_wdata[15:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  rcdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .push      (push),
    .push_desc (push_desc)
  );

  rcdf_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .qstat     (qstat)
  );

  rcdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .qstat     (qstat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // queue takes no descriptor while full unless one is popped in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop))
    else $error("descriptor pushed into a full queue");

  // a descriptor leaves the queue only as its last byte is loaded
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.last_byte))
    else $error("queue popped without a last frame byte");

  // a partly sent frame keeps its descriptor in the queue
  a_mid_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last_byte) |-> !qstat.empty)
    else $error("frame in flight without a queued descriptor");

endmodule

[rtl/rcdf_front.sv]
// ----------------------------------------------------------------------------
// rcdf_front
// Accepts requests, updates button/switch/beep state, scales the sticks in a
// two-stage multiply pipeline and pushes one frame descriptor to the queue.
// ----------------------------------------------------------------------------
module rcdf_front import rcdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rcdf_req_if.sink    in_ch,
  input  rcdf_cfg_t   cfg,
  input  rcdf_qstat_t qstat,
  output logic        push,
  output rcdf_desc_t  push_desc
);

  // per-request button counter step
  function automatic rcdf_btn_t btn_step(input logic pressed, input logic [6:0] cnt);
    rcdf_btn_t r;
    logic [6:0] c;
    c = cnt;
    r.fired = 1'b0;
    if (pressed) begin
      if (c == 7'd0) begin
        r.fired = 1'b1;
        c = 7'd1;
      end
    end else if (c > BTN_RELEASE) begin
      c = 7'd0;
    end
    if (c != 7'd0 && c < BTN_CAP) begin
      c = c + 7'd1;
    end
    r.cnt = c;
    return r;
  endfunction

  // state
  logic [6:0]  cnt_r [4];
  logic [6:0]  cnt_nxt [4];
  logic        headless_r, headless_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [31:0] frame_count_r;

  // pipeline stage 1: offset magnitude times 63
  logic        p1_v_r;
  logic [17:0] p1_m_r [4];
  logic [3:0]  p1_neg_r;
  logic [7:0]  p1_flags_r;
  logic [6:0]  p1_ev_r;
  logic [31:0] p1_cnt_r;

  // pipeline stage 2: quotient
  logic        p2_v_r;
  logic [9:0]  p2_q_r [4];
  logic [3:0]  p2_neg_r;
  logic [7:0]  p2_flags_r;
  logic [6:0]  p2_ev_r;
  logic [31:0] p2_cnt_r;

  logic        adv;
  logic        accept;
  logic [11:0] stick_in [4];
  logic [11:0] btn_in [4];
  rcdf_btn_t   btn_res [4];
  logic [3:0]  pulse;
  logic        head_sw, flip_sw, beep;
  logic [11:0] mag [4];
  logic [3:0]  neg;
  logic [7:0]  flags;
  logic [6:0]  ev;
  logic [7:0]  stick_byte [4];

  // pipeline moves whenever the last stage can drain
  assign adv         = !p2_v_r || !qstat.full;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign push        = p2_v_r && !qstat.full;

  assign stick_in[0] = in_ch.roll_value;
  assign stick_in[1] = in_ch.pitch_value;
  assign stick_in[2] = in_ch.throttle_value;
  assign stick_in[3] = in_ch.yaw_value;
  assign btn_in[0]   = in_ch.takeoff_value;
  assign btn_in[1]   = in_ch.landing_value;
  assign btn_in[2]   = in_ch.stop_value;
  assign btn_in[3]   = in_ch.gyro_value;

  // button counters and pulse flags
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      btn_res[i] = btn_step(btn_in[i] >= cfg.button_thr, cnt_r[i]);
      cnt_nxt[i] = btn_res[i].cnt;
      pulse[i]   = (btn_res[i].cnt != 7'd0) && (btn_res[i].cnt <= cfg.pulse_frames);
    end
  end

  // switches, headless edges and flip beep
  always_comb begin
    head_sw      = in_ch.headless_value > cfg.switch_thr;
    flip_sw      = in_ch.flip_value > cfg.switch_thr;
    headless_nxt = head_sw;
    beep         = flip_sw && (in_ch.now_ms > deadline_r);
    deadline_nxt = beep ? (in_ch.now_ms + 32'(cfg.beep_interval)) : deadline_r;
    ev = {beep, headless_r && !head_sw, !headless_r && head_sw,
          btn_res[3].fired, btn_res[2].fired, btn_res[1].fired, btn_res[0].fired};
    flags = FLAG_BASE | {pulse[3], 2'b00, head_sw, flip_sw, pulse[2], pulse[1], pulse[0]};
  end

  // stick offset magnitude and sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg[i] = stick_in[i] < STICK_MID;
      mag[i] = neg[i] ? (STICK_MID - stick_in[i]) : (stick_in[i] - STICK_MID);
    end
  end

  // request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cnt_r[i] <= 7'd0;
      headless_r    <= 1'b0;
      deadline_r    <= 32'd0;
      frame_count_r <= 32'd0;
    end else if (accept) begin
      for (int i = 0; i < 4; i++) cnt_r[i] <= cnt_nxt[i];
      headless_r    <= headless_nxt;
      deadline_r    <= deadline_nxt;
      frame_count_r <= frame_count_r + 32'd1;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_ch.valid;
      p2_v_r <= p1_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p1_m_r[i] <= {mag[i], 6'b0} - 18'(mag[i]);
        p2_q_r[i] <= 10'((37'(p1_m_r[i]) * 37'(SCALE_RECIP)) >> SCALE_SHIFT);
      end
      p1_neg_r   <= neg;
      p1_flags_r <= flags;
      p1_ev_r    <= ev;
      p1_cnt_r   <= frame_count_r;
      p2_neg_r   <= p1_neg_r;
      p2_flags_r <= p1_flags_r;
      p2_ev_r    <= p1_ev_r;
      p2_cnt_r   <= p1_cnt_r;
    end
  end

  // sign, bias and check byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      stick_byte[i] = (p2_neg_r[i] ? (8'd0 - p2_q_r[i][7:0]) : p2_q_r[i][7:0]) + STICK_BIAS;
    end
    push_desc.frame_count = p2_cnt_r;
    push_desc.roll        = stick_byte[0];
    push_desc.pitch       = stick_byte[1];
    push_desc.throttle    = stick_byte[2];
    push_desc.yaw         = stick_byte[3];
    push_desc.flags       = p2_flags_r;
    push_desc.check       = stick_byte[0] ^ stick_byte[1] ^ stick_byte[2]
                          ^ stick_byte[3] ^ p2_flags_r;
    push_desc.event_mask  = p2_ev_r;
  end

endmodule

[rtl/rcdf_queue.sv]
// ----------------------------------------------------------------------------
// rcdf_queue
// Short descriptor queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module rcdf_queue import rcdf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rcdf_desc_t  push_desc,
  input  logic        pop,
  output rcdf_desc_t  head_desc,
  output rcdf_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rcdf_desc_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign qstat.full  = cnt_r == CNT_FULL;
  assign qstat.empty = cnt_r == '0;
  assign head_desc   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      priority if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push)     cnt_r <= cnt_r - 1'b1;
      else                       cnt_r <= cnt_r;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

[rtl/rcdf_back.sv]
// ----------------------------------------------------------------------------
// rcdf_back
// Serializes the head descriptor into forty frame bytes through an output
// register, one byte per cycle while out_ch.ready holds.
// ----------------------------------------------------------------------------
module rcdf_back import rcdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rcdf_desc_t  head_desc,
  input  rcdf_qstat_t qstat,
  output logic        pop,
  rcdf_rsp_if.source  out_ch
);

  logic [IDX_W-1:0] idx_r;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [6:0]       ev_r;
  logic             take;
  logic             at_last;
  logic [7:0]       sel_byte;

  assign take    = !qstat.empty && (!valid_r || out_ch.ready);
  assign at_last = idx_r == IDX_LAST;
  assign pop     = take && at_last;

  assign out_ch.valid      = valid_r;
  assign out_ch.frame_byte = byte_r;
  assign out_ch.last_byte  = last_r;
  assign out_ch.event_mask = ev_r;

  // byte at the current frame position
  always_comb begin
    priority if (idx_r < IDX_CNT0) begin
      sel_byte = HEADER[idx_r[3:0]];
    end else if (idx_r < IDX_SYNC) begin
      unique case (idx_r[1:0])
        2'd0:    sel_byte = head_desc.frame_count[7:0];
        2'd1:    sel_byte = head_desc.frame_count[15:8];
        2'd2:    sel_byte = head_desc.frame_count[23:16];
        default: sel_byte = head_desc.frame_count[31:24];
      endcase
    end else if (idx_r == IDX_SYNC) begin
      sel_byte = SYNC_BYTE;
    end else if (idx_r == IDX_ROLL) begin
      sel_byte = head_desc.roll;
    end else if (idx_r == IDX_PITCH) begin
      sel_byte = head_desc.pitch;
    end else if (idx_r == IDX_THR) begin
      sel_byte = head_desc.throttle;
    end else if (idx_r == IDX_YAW) begin
      sel_byte = head_desc.yaw;
    end else if (idx_r == IDX_FLAGS) begin
      sel_byte = head_desc.flags;
    end else if (idx_r == IDX_CHECK) begin
      sel_byte = head_desc.check;
    end else if (idx_r == IDX_END) begin
      sel_byte = END_BYTE;
    end else begin
      sel_byte = 8'h00;
    end
  end

  // position counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (take) idx_r <= at_last ? '0 : idx_r + 1'b1;
      if (take)              valid_r <= 1'b1;
      else if (out_ch.ready) valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= sel_byte;
      last_r <= at_last;
      ev_r   <= head_desc.event_mask;
    end
  end

endmodule
